// ===== sv/rdb_pkg.sv =====
// Shared types and codes for the reversible deque buffer.
// No dependencies; the top level and rdb_ctrl take names from here.
package rdb_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 11;

  typedef enum logic [1:0] {
    REQ_PUSH_HEAD = 2'd0,
    REQ_PUSH_TAIL = 2'd1,
    REQ_POP_HEAD  = 2'd2,
    REQ_REVERSE   = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [WORD_W-1:0] data_in;
  } req_word_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] data_out;
    logic [COUNT_W-1:0]       count;
  } rsp_word_t;

  // Status of one request as the controller settles it.
  typedef struct packed {
    logic               ok;
    logic               pop;
    logic [COUNT_W-1:0] count;
  } ctrl_res_t;

endpackage

// ===== sv/reversible_deque_buffer.sv =====
// Top level of the reversible deque buffer: controller, element RAM, result stages.
// Uses rdb_pkg, rdb_ctrl and rdb_ram.
//
// Use:
//   Requests enter on req (req_valid / req_ready): push at head, push at tail,
//   pop head, or reverse. Each request returns exactly one word on rsp
//   (rsp_valid / rsp_ready) with ok, the popped value (zero unless a pop
//   succeeded) and the count after the request.
//   Indices, count and the direction flag update at the accepting edge, where
//   a pop also issues its RAM read; the data joins the status in the result
//   stage. The output register takes the response word when the result
//   stage moves on, and rsp_valid rises with it.
//   Throughput is one request per cycle while rsp is taken, set by the
//   single write and single read port of the element RAM; reverse only
//   flips the direction flag. A result stage and an output register sit
//   between the two channels, so a new request is taken while a finished
//   response waits. When the receiver stalls, both stages fill and req_ready
//   drops; it rises again as soon as rsp is taken. The RAM read data holds
//   while stalled since no new read is issued until the result stage moves on.
//   Reset (rst, synchronous) empties the queue and clears the direction flag
//   and both stages; the RAM contents are left as they are and are never
//   read before being written.
module reversible_deque_buffer #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  rdb_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rdb_pkg::rsp_word_t rsp
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                  acc;
  logic                  we, re;
  logic [IDX_W-1:0]      waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  rdb_pkg::ctrl_res_t    res;

  // Result stage: status of the last accepted request, RAM data alongside.
  logic               s1_valid;
  rdb_pkg::ctrl_res_t s1;
  logic               s1_move;
  logic [DATA_WIDTH+rdb_pkg::WORD_W-1:0] rdata_ext;
  rdb_pkg::rsp_word_t s1_word;

  assign s1_move   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_move;
  assign acc       = req_valid && req_ready;

  rdb_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .acc   (acc),
    .req   (req),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .res   (res)
  );

  rdb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Take the low word of the stored value; zero it unless a pop succeeded.
  assign rdata_ext        = {{rdb_pkg::WORD_W{1'b0}}, rdata};
  assign s1_word.ok       = s1.ok;
  assign s1_word.count    = s1.count;
  assign s1_word.data_out = s1.pop ? rdata_ext[rdb_pkg::WORD_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: advance on accept / move, hold otherwise.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1 <= res;
    end
    if (s1_move) begin
      rsp <= s1_word;
    end
  end

endmodule

// ===== sv/rdb_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rdb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rdb_ctrl.sv =====
// Index, count and direction control of the reversible deque buffer.
// Uses rdb_pkg; drives the write and read ports of the element RAM.
module rdb_ctrl #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     acc,
  input  rdb_pkg::req_word_t       req,
  output logic                     we,
  output logic [$clog2(DEPTH)-1:0] waddr,
  output logic [DATA_WIDTH-1:0]    wdata,
  output logic                     re,
  output logic [$clog2(DEPTH)-1:0] raddr,
  output rdb_pkg::ctrl_res_t       res
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  logic [IDX_W-1:0] front, front_next;
  logic [IDX_W-1:0] back, back_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             rev, rev_next;

  logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec;
  logic [DATA_WIDTH+rdb_pkg::WORD_W-1:0] data_ext;
  logic [CNT_W+rdb_pkg::COUNT_W-1:0]     cnt_ext;
  rdb_pkg::req_t    op;
  logic             at_low;

  assign front_inc = (front == LAST) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? LAST : front - 1'b1;
  assign back_inc  = (back == LAST) ? '0 : back + 1'b1;
  assign back_dec  = (back == '0) ? LAST : back - 1'b1;

  assign data_ext = {{DATA_WIDTH{1'b0}}, req.data_in};
  assign wdata    = data_ext[DATA_WIDTH-1:0];
  assign op       = rdb_pkg::req_t'(req.req_type);
  assign at_low   = (op == rdb_pkg::REQ_PUSH_HEAD) ^ rev;

  always_comb begin
    front_next = front;
    back_next  = back;
    cnt_next   = cnt;
    rev_next   = rev;
    we         = 1'b0;
    waddr      = back;
    re         = 1'b0;
    raddr      = front;
    res.ok     = 1'b0;
    res.pop    = 1'b0;
    if (acc) begin
      case (op)
        rdb_pkg::REQ_PUSH_HEAD, rdb_pkg::REQ_PUSH_TAIL: begin
          if (cnt != FULL) begin
            we       = 1'b1;
            cnt_next = cnt + 1'b1;
            res.ok   = 1'b1;
            if (at_low) begin
              waddr      = front_dec;
              front_next = front_dec;
            end else begin
              waddr     = back;
              back_next = back_inc;
            end
          end
        end
        rdb_pkg::REQ_POP_HEAD: begin
          if (cnt != '0) begin
            re       = 1'b1;
            cnt_next = cnt - 1'b1;
            res.ok   = 1'b1;
            res.pop  = 1'b1;
            if (rev) begin
              raddr     = back_dec;
              back_next = back_dec;
            end else begin
              raddr      = front;
              front_next = front_inc;
            end
          end
        end
        default: begin
          rev_next = ~rev;
          res.ok   = 1'b1;
        end
      endcase
    end
    cnt_ext   = {{rdb_pkg::COUNT_W{1'b0}}, cnt_next};
    res.count = cnt_ext[rdb_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      cnt   <= '0;
      rev   <= 1'b0;
    end else begin
      front <= front_next;
      back  <= back_next;
      cnt   <= cnt_next;
      rev   <= rev_next;
    end
  end

endmodule
